// ===== rtl/core/htw_pkg.sv =====
// Shared types and constants of the hashed timing wheel.
// Holds operation and result codes, controller states and the
// command and status structs between controller and datapath.
package htw_pkg;

   // Operation codes of an input item
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_SCHED  = 2'd1;
   localparam logic [1:0] OP_CANCEL = 2'd2;

   // Result kinds
   localparam logic [2:0] KIND_OK    = 3'd0;
   localparam logic [2:0] KIND_FIRED = 3'd1;
   localparam logic [2:0] KIND_NONE  = 3'd2;
   localparam logic [2:0] KIND_BUSY  = 3'd3;
   localparam logic [2:0] KIND_IDLE  = 3'd4;

   // Field widths fixed by the interface
   localparam int unsigned OP_W   = 2;
   localparam int unsigned ID_W   = 6;
   localparam int unsigned KIND_W = 3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_WRITE,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_FLUSH
   } htw_state_type;

   // Controller to datapath
   typedef struct packed {
      logic              load_req;
      logic              tick_start;
      logic              reply;
      logic [KIND_W-1:0] reply_kind;
      logic              cancel_clr;
      logic              div_start;
      logic              sched_wr;
      logic              scan_rd;
      logic              dec_turns;
      logic              fire;
      logic              scan_next;
      logic              flush;
   } htw_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            id_valid;
      logic            id_active;
      logic            div_busy;
      logic            out_free;
      logic            hit;
      logic            turns_zero;
      logic            pend_valid;
      logic            scan_end;
   } htw_stat_type;

endpackage

// ===== rtl/core/hashed_timing_wheel.sv =====
// Hashed timing wheel, top level. A schedule is accepted, decoded, split
// into turns and bucket by a reciprocal multiply over the low and then the
// high half of the delay, seen done, and written to the table with its result.
// A cancel is accepted and answered. A tick visits every event slot in turn:
// its bucket and turn count are read from the slot table, then it is updated,
// fired or passed over, so at most one fired item leaves per visited slot.
// A stalled result channel holds the block back. Only one item is worked on
// at a time; the next is taken while the last result still waits. The active
// and pending bits are cleared at reset, so no clearing pass is needed.
module hashed_timing_wheel
   import htw_pkg::*;
#(
   parameter int unsigned WHEEL_SLOTS = 128,
   parameter int unsigned EVENT_SLOTS = 64,
   parameter int unsigned DELAY_BITS  = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [ID_W-1:0]       req_event_id,
   input  logic [DELAY_BITS-1:0] req_delay,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic [ID_W-1:0]       rsp_fired_id,
   output logic                  rsp_last
);

   htw_cmd_type  cmd;
   htw_stat_type stat;

   htw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   htw_dpath #(
      .WHEEL_SLOTS (WHEEL_SLOTS),
      .EVENT_SLOTS (EVENT_SLOTS),
      .DELAY_BITS  (DELAY_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_operation (req_operation),
      .req_event_id  (req_event_id),
      .req_delay     (req_delay),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_fired_id  (rsp_fired_id),
      .rsp_last      (rsp_last)
   );

endmodule

// ===== rtl/core/htw_div.sv =====
// Divider by a constant through a reciprocal multiply, over the two halves of the dividend.
// Used by the datapath to split a delay into wheel turns and bucket offset.
// No package dependency.
module htw_div #(
   parameter int unsigned DIVISOR    = 128,
   parameter int unsigned DIVIDEND_W = 24,
   parameter int unsigned REM_W      = 7,
   parameter int unsigned QUO_W      = 17
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   output logic                  busy,
   output logic [QUO_W-1:0]      quotient,
   output logic [REM_W-1:0]      remainder
);

   // q = (x * RECIP) >> SHIFT is exact for every x below 2**DIVIDEND_W
   localparam int unsigned LOG_D   = $clog2(DIVISOR);
   localparam int unsigned SHIFT   = DIVIDEND_W + LOG_D;
   localparam int unsigned RECIP_W = DIVIDEND_W + 2;
   localparam int unsigned LO_W    = DIVIDEND_W / 2;
   localparam int unsigned HI_W    = DIVIDEND_W - LO_W;
   localparam int unsigned MUL_W   = HI_W + RECIP_W;
   localparam int unsigned PROD_W  = (SHIFT + QUO_W > DIVIDEND_W + RECIP_W)
                                   ? SHIFT + QUO_W : DIVIDEND_W + RECIP_W;
   localparam longint unsigned RECIP_VAL = ((64'd1 << SHIFT) / DIVISOR) + 64'd1;
   localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(RECIP_VAL);
   localparam logic [REM_W-1:0]   DIV_LOW = REM_W'(DIVISOR);

   logic                  run_ff, run_in;
   logic                  step_ff, step_in;
   logic [DIVIDEND_W-1:0] x_ff, x_in;
   logic [PROD_W-1:0]     acc_ff, acc_in;
   logic [QUO_W-1:0]      quo_ff, quo_in;
   logic [MUL_W-1:0]      part_lo;
   logic [MUL_W-1:0]      part_hi;
   logic [PROD_W-1:0]     total;
   logic [REM_W-1:0]      quo_low;

   // Partial products of the low and the high half of the dividend
   assign part_lo = MUL_W'(x_ff[LO_W-1:0]) * MUL_W'(RECIP);
   assign part_hi = MUL_W'(x_ff[DIVIDEND_W-1:LO_W]) * MUL_W'(RECIP);
   assign total   = acc_ff + (PROD_W'(part_hi) << LO_W);

   // Low half first, then the high half and the shift
   always_comb begin
      run_in  = run_ff;
      step_in = step_ff;
      x_in    = x_ff;
      acc_in  = acc_ff;
      quo_in  = quo_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = 1'b0;
         x_in    = dividend;
      end else if (run_ff) begin
         if (!step_ff) begin
            acc_in  = PROD_W'(part_lo);
            step_in = 1'b1;
         end else begin
            quo_in = total[SHIFT +: QUO_W];
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      acc_ff <= acc_in;
      quo_ff <= quo_in;
   end

   // Remainder fits REM_W bits, so low bits of x - q * d are enough
   assign quo_low   = REM_W'(quo_ff);
   assign remainder = REM_W'(x_ff) - REM_W'(quo_low * DIV_LOW);

   assign busy     = run_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/htw_dpath.sv =====
// Datapath of the hashed timing wheel: request register, wheel position,
// slot tables, scan index, pending fired id and the result register.
// Depends on htw_pkg and htw_div.
module htw_dpath
   import htw_pkg::*;
#(
   parameter int unsigned WHEEL_SLOTS = 128,
   parameter int unsigned EVENT_SLOTS = 64,
   parameter int unsigned DELAY_BITS  = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  htw_cmd_type           cmd,
   output htw_stat_type          stat,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [ID_W-1:0]       req_event_id,
   input  logic [DELAY_BITS-1:0] req_delay,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic [ID_W-1:0]       rsp_fired_id,
   output logic                  rsp_last
);

   localparam int unsigned POS_W    = $clog2(WHEEL_SLOTS);
   localparam int unsigned FLOOR_LG = $clog2(WHEEL_SLOTS + 1) - 1;
   localparam int unsigned TURN_W   = (DELAY_BITS > FLOOR_LG) ? DELAY_BITS - FLOOR_LG : 1;
   localparam int unsigned IDX_W    = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;

   // Request register
   logic [OP_W-1:0]       req_op_ff;
   logic [ID_W-1:0]       req_id_ff;
   logic [DELAY_BITS-1:0] req_delay_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_op_ff    <= req_operation;
         req_id_ff    <= req_event_id;
         req_delay_ff <= req_delay;
      end
   end

   logic [IDX_W-1:0] req_idx;
   logic             id_valid;
   assign req_idx  = req_id_ff[IDX_W-1:0];
   assign id_valid = ({1'b0, req_id_ff} < (ID_W+1)'(EVENT_SLOTS));

   // Delay minus one, with zero taken as one, split into turns and offset
   logic [DELAY_BITS-1:0] delay_m1;
   logic                  div_busy;
   logic [TURN_W-1:0]     div_turns;
   logic [POS_W-1:0]      div_rem;

   assign delay_m1 = (req_delay_ff == '0) ? '0 : req_delay_ff - DELAY_BITS'(1);

   htw_div #(
      .DIVISOR    (WHEEL_SLOTS),
      .DIVIDEND_W (DELAY_BITS),
      .REM_W      (POS_W),
      .QUO_W      (TURN_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (delay_m1),
      .busy      (div_busy),
      .quotient  (div_turns),
      .remainder (div_rem)
   );

   // Wheel position
   logic [POS_W-1:0] pos_ff, pos_in;

   always_comb begin
      pos_in = pos_ff;
      if (cmd.tick_start) begin
         if (pos_ff == POS_W'(WHEEL_SLOTS - 1)) pos_in = '0;
         else                                   pos_in = pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) pos_ff <= '0;
      else       pos_ff <= pos_in;
   end

   // Target bucket: position + 1 + offset, folded once
   logic [POS_W:0]   bucket_sum;
   logic [POS_W-1:0] new_bucket;
   assign bucket_sum = {1'b0, pos_ff} + (POS_W+1)'(1) + {1'b0, div_rem};
   assign new_bucket = (bucket_sum >= (POS_W+1)'(WHEEL_SLOTS))
                     ? POS_W'(bucket_sum - (POS_W+1)'(WHEEL_SLOTS))
                     : bucket_sum[POS_W-1:0];

   // Scan index
   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;

   always_comb begin
      scan_idx_in = scan_idx_ff;
      if (cmd.tick_start)     scan_idx_in = '0;
      else if (cmd.scan_next) scan_idx_in = scan_idx_ff + IDX_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) scan_idx_ff <= '0;
      else       scan_idx_ff <= scan_idx_in;
   end

   // Slot tables: bucket and turns, one write and one registered read port
   logic [POS_W-1:0]  bucket_mem [EVENT_SLOTS];
   logic [TURN_W-1:0] turns_mem  [EVENT_SLOTS];
   logic [POS_W-1:0]  rd_bucket_ff;
   logic [TURN_W-1:0] rd_turns_ff;
   logic [IDX_W-1:0]  wr_idx;
   logic [TURN_W-1:0] wr_turns;
   logic              wr_turns_en;

   assign wr_idx      = cmd.sched_wr ? req_idx : scan_idx_ff;
   assign wr_turns    = cmd.sched_wr ? div_turns : rd_turns_ff - TURN_W'(1);
   assign wr_turns_en = cmd.sched_wr | cmd.dec_turns;

   always_ff @(posedge clock) begin
      if (cmd.sched_wr) bucket_mem[wr_idx] <= new_bucket;
      if (wr_turns_en)  turns_mem[wr_idx]  <= wr_turns;
      if (cmd.scan_rd) begin
         rd_bucket_ff <= bucket_mem[scan_idx_ff];
         rd_turns_ff  <= turns_mem[scan_idx_ff];
      end
   end

   // Slot active bits
   logic [EVENT_SLOTS-1:0] active_ff, active_in;

   always_comb begin
      active_in = active_ff;
      if (cmd.sched_wr)   active_in[req_idx]     = 1'b1;
      if (cmd.cancel_clr) active_in[req_idx]     = 1'b0;
      if (cmd.fire)       active_in[scan_idx_ff] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) active_ff <= '0;
      else       active_ff <= active_in;
   end

   // Fired id held back until it is known whether it is the last one
   logic            pend_valid_ff, pend_valid_in;
   logic [ID_W-1:0] pend_id_ff;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (cmd.tick_start) pend_valid_in = 1'b0;
      else if (cmd.fire)  pend_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) pend_valid_ff <= 1'b0;
      else       pend_valid_ff <= pend_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.fire) pend_id_ff <= ID_W'(scan_idx_ff);
   end

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              emit;

   always_comb begin
      emit        = 1'b0;
      rsp_kind_in = rsp_kind_ff;
      rsp_id_in   = rsp_id_ff;
      rsp_last_in = rsp_last_ff;
      if (cmd.reply) begin
         emit        = 1'b1;
         rsp_kind_in = cmd.reply_kind;
         rsp_id_in   = req_id_ff;
         rsp_last_in = 1'b1;
      end else if (cmd.fire && pend_valid_ff) begin
         emit        = 1'b1;
         rsp_kind_in = KIND_FIRED;
         rsp_id_in   = pend_id_ff;
         rsp_last_in = 1'b0;
      end else if (cmd.flush) begin
         emit        = 1'b1;
         rsp_kind_in = pend_valid_ff ? KIND_FIRED : KIND_NONE;
         rsp_id_in   = pend_valid_ff ? pend_id_ff : '0;
         rsp_last_in = 1'b1;
      end
      rsp_valid_in = emit | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_fired_id = rsp_id_ff;
   assign rsp_last     = rsp_last_ff;

   // Status to the controller
   always_comb begin
      stat.op         = req_op_ff;
      stat.id_valid   = id_valid;
      stat.id_active  = id_valid && active_ff[req_idx];
      stat.div_busy   = div_busy;
      stat.out_free   = ~rsp_valid_ff | rsp_ready;
      stat.hit        = active_ff[scan_idx_ff] && (rd_bucket_ff == pos_ff);
      stat.turns_zero = (rd_turns_ff == '0);
      stat.pend_valid = pend_valid_ff;
      stat.scan_end   = (scan_idx_ff == IDX_W'(EVENT_SLOTS - 1));
   end

endmodule

// ===== rtl/core/htw_ctrl.sv =====
// Controller of the hashed timing wheel: sequences decode, schedule,
// cancel and the tick scan over the event slots.
// Depends on htw_pkg.
module htw_ctrl
   import htw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  htw_stat_type stat,
   output htw_cmd_type  cmd
);

   htw_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            case (stat.op)
               OP_TICK: state_in = ST_SCAN_RD;
               OP_SCHED: begin
                  if (stat.id_valid && !stat.id_active) state_in = ST_DIV;
                  else if (stat.out_free)               state_in = ST_IDLE;
               end
               OP_CANCEL: begin
                  if (stat.out_free) state_in = ST_IDLE;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_DIV: begin
            if (!stat.div_busy) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         ST_SCAN_RD: state_in = ST_SCAN_EV;
         ST_SCAN_EV: begin
            if (!stat.hit || !stat.turns_zero || !stat.pend_valid || stat.out_free) begin
               state_in = stat.scan_end ? ST_FLUSH : ST_SCAN_RD;
            end
         end
         ST_FLUSH: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ST_CHECK: begin
            case (stat.op)
               OP_TICK: cmd.tick_start = 1'b1;
               OP_SCHED: begin
                  if (stat.id_valid && !stat.id_active) begin
                     cmd.div_start = 1'b1;
                  end else if (stat.out_free) begin
                     cmd.reply      = 1'b1;
                     cmd.reply_kind = KIND_BUSY;
                  end
               end
               OP_CANCEL: begin
                  if (stat.out_free) begin
                     cmd.reply      = 1'b1;
                     cmd.reply_kind = stat.id_active ? KIND_OK : KIND_IDLE;
                     cmd.cancel_clr = stat.id_active;
                  end
               end
               default: cmd = '0;
            endcase
         end
         ST_DIV: cmd = '0;
         ST_WRITE: begin
            if (stat.out_free) begin
               cmd.sched_wr   = 1'b1;
               cmd.reply      = 1'b1;
               cmd.reply_kind = KIND_OK;
            end
         end
         ST_SCAN_RD: cmd.scan_rd = 1'b1;
         ST_SCAN_EV: begin
            // Count a turn down, fire, or pass over this slot
            if (stat.hit && !stat.turns_zero) begin
               cmd.dec_turns = 1'b1;
               cmd.scan_next = !stat.scan_end;
            end else if (stat.hit) begin
               if (!stat.pend_valid || stat.out_free) begin
                  cmd.fire      = 1'b1;
                  cmd.scan_next = !stat.scan_end;
               end
            end else begin
               cmd.scan_next = !stat.scan_end;
            end
         end
         ST_FLUSH: cmd.flush = stat.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

// ===== rtl/core/htw_checker.sv =====
// Port-level checks for the hashed timing wheel, bound to the top level.
// Depends on htw_pkg and hashed_timing_wheel.
module htw_port_checks
   import htw_pkg::*;
#(
   parameter int unsigned DELAY_BITS = 24
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic [OP_W-1:0]       req_operation,
   input logic [ID_W-1:0]       req_event_id,
   input logic [DELAY_BITS-1:0] req_delay,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [KIND_W-1:0]     rsp_kind,
   input logic [ID_W-1:0]       rsp_fired_id,
   input logic                  rsp_last
);

   // A waiting input item holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=>
         req_valid && $stable(req_operation) && $stable(req_event_id) && $stable(req_delay))
      else $error("input item changed while waiting");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_kind) && $stable(rsp_fired_id) && $stable(rsp_last))
      else $error("result changed while stalled");

   // Only fired items come in groups
   a_group_fired: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_kind == KIND_FIRED)
      else $error("non-final result that is not a firing");

   // No new item is taken while a group of firings is still open
   a_group_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |-> !req_ready)
      else $error("item accepted in the middle of a tick");

   // An empty tick reports id zero as the only result
   a_empty_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_NONE |-> rsp_fired_id == '0 && rsp_last)
      else $error("malformed empty tick result");

endmodule

bind hashed_timing_wheel htw_port_checks #(.DELAY_BITS(DELAY_BITS)) u_htw_port_checks (.*);

// ===== verif/htw_checker.sv =====
// Checker for the hashed timing wheel: watches both channels, keeps its own
// copy of wheel position and event slots, and compares every result item.
// Depends on htw_pkg for operation codes, result kinds and field widths.
`timescale 1ns / 1ps

module htw_checker
   import htw_pkg::*;
#(
   parameter int unsigned WHEEL_SLOTS = 128,
   parameter int unsigned EVENT_SLOTS = 64,
   parameter int unsigned DELAY_BITS  = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [ID_W-1:0]       req_event_id,
   input  logic [DELAY_BITS-1:0] req_delay,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [KIND_W-1:0]     rsp_kind,
   input  logic [ID_W-1:0]       rsp_fired_id,
   input  logic                  rsp_last,
   output int                    mismatches,
   output int                    outstanding,
   output int                    items_seen,
   output int                    results_seen,
   output int                    fired_seen,
   output int                    errors_seen
);

   localparam int unsigned POS_W = $clog2(WHEEL_SLOTS);

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   id;
      logic              last;
   } wheel_result_type;

   // Results still owed by the block, oldest first
   wheel_result_type due_results[$];

   // Shadow of the wheel
   logic [POS_W-1:0]      wheel_pos;
   logic [EVENT_SLOTS-1:0] armed;
   logic [POS_W-1:0]      home_bucket [EVENT_SLOTS];
   logic [DELAY_BITS-1:0] turns_left  [EVENT_SLOTS];

   task automatic report_mismatch(input string what);
      if (mismatches < 40)
         $display("t=%0t mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic owe_result(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                             input logic last);
      wheel_result_type r;
      r.kind = kind;
      r.id   = id;
      r.last = last;
      due_results.push_back(r);
   endtask

   // Apply one accepted item to the shadow wheel and queue what it causes
   task automatic apply_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                             input logic [DELAY_BITS-1:0] dly);
      int               fired_ids[$];
      longint unsigned  span;
      span = dly;
      if (span == 0)
         span = 1;
      case (op)
         OP_TICK: begin
            wheel_pos = POS_W'((int'(wheel_pos) + 1) % WHEEL_SLOTS);
            for (int i = 0; i < EVENT_SLOTS; i++) begin
               if (armed[i] && home_bucket[i] == wheel_pos) begin
                  if (turns_left[i] != '0) begin
                     turns_left[i] = turns_left[i] - 1'b1;
                  end else begin
                     armed[i] = 1'b0;
                     fired_ids.push_back(i);
                  end
               end
            end
            if (fired_ids.size() == 0) begin
               owe_result(KIND_NONE, '0, 1'b1);
            end else begin
               foreach (fired_ids[k])
                  owe_result(KIND_FIRED, ID_W'(fired_ids[k]), k == fired_ids.size() - 1);
            end
         end
         OP_SCHED: begin
            if (int'(id) >= EVENT_SLOTS) begin
               owe_result(KIND_BUSY, id, 1'b1);
            end else if (armed[id]) begin
               owe_result(KIND_BUSY, id, 1'b1);
            end else begin
               home_bucket[id] = POS_W'((span + longint'(wheel_pos)) % WHEEL_SLOTS);
               turns_left[id]  = DELAY_BITS'((span - 1) / WHEEL_SLOTS);
               armed[id]       = 1'b1;
               owe_result(KIND_OK, id, 1'b1);
            end
         end
         OP_CANCEL: begin
            if (int'(id) >= EVENT_SLOTS) begin
               owe_result(KIND_IDLE, id, 1'b1);
            end else if (!armed[id]) begin
               owe_result(KIND_IDLE, id, 1'b1);
            end else begin
               armed[id] = 1'b0;
               owe_result(KIND_OK, id, 1'b1);
            end
         end
         default: ;  // unused code: no result
      endcase
   endtask

   // Compare one accepted result item with the oldest one owed
   task automatic check_result();
      wheel_result_type want;
      if (due_results.size() == 0) begin
         report_mismatch($sformatf("unexpected result kind %0d id %0d last %0d",
                                   rsp_kind, rsp_fired_id, rsp_last));
      end else begin
         want = due_results.pop_front();
         if (rsp_kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", rsp_kind, want.kind));
         if (rsp_fired_id !== want.id)
            report_mismatch($sformatf("fired_id %0d, expected %0d", rsp_fired_id, want.id));
         if (rsp_last !== want.last)
            report_mismatch($sformatf("last %0d, expected %0d (id %0d)",
                                      rsp_last, want.last, want.id));
      end
      results_seen++;
      if (rsp_kind == KIND_FIRED)
         fired_seen++;
      if (rsp_kind == KIND_BUSY || rsp_kind == KIND_IDLE)
         errors_seen++;
   endtask

   // Results are taken before the new item so an early result never
   // matches an expectation queued at the same edge
   always @(posedge clock) begin
      if (reset) begin
         wheel_pos    = '0;
         armed        = '0;
         due_results.delete();
         mismatches   = 0;
         items_seen   = 0;
         results_seen = 0;
         fired_seen   = 0;
         errors_seen  = 0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_result();
         if (req_valid && req_ready) begin
            apply_item(req_operation, req_event_id, req_delay);
            items_seen++;
         end
      end
      outstanding = due_results.size();
   end

endmodule

// ===== verif/hashed_timing_wheel_tb.sv =====
// Testbench top of the hashed timing wheel: clock, reset, item stimulus,
// result back-pressure, watchdog and verdict. Depends on htw_pkg, the
// hashed_timing_wheel block and the htw_checker module.
`timescale 1ns / 1ps

module hashed_timing_wheel_tb;
   import htw_pkg::*;

   localparam int unsigned WHEEL_SLOTS = 128;
   localparam int unsigned EVENT_SLOTS = 64;
   localparam int unsigned DELAY_BITS  = 24;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam int STALL_LIMIT   = 3000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 2 * EVENT_SLOTS + 40;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [OP_W-1:0]       req_operation = OP_TICK;
   logic [ID_W-1:0]       req_event_id = '0;
   logic [DELAY_BITS-1:0] req_delay = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [KIND_W-1:0]     rsp_kind;
   logic [ID_W-1:0]       rsp_fired_id;
   logic                  rsp_last;

   int mismatches, outstanding, items_seen, results_seen, fired_seen, errors_seen;

   // Stimulus control shared with the result side
   bit no_idle = 1'b0;
   int hold_asked = 0;
   int hold_done = 0;
   int sent_items = 0;
   int stall_cycles = 0;

   hashed_timing_wheel #(
      .WHEEL_SLOTS(WHEEL_SLOTS),
      .EVENT_SLOTS(EVENT_SLOTS),
      .DELAY_BITS (DELAY_BITS)
   ) uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_operation(req_operation),
      .req_event_id (req_event_id),
      .req_delay    (req_delay),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_kind     (rsp_kind),
      .rsp_fired_id (rsp_fired_id),
      .rsp_last     (rsp_last)
   );

   htw_checker #(
      .WHEEL_SLOTS(WHEEL_SLOTS),
      .EVENT_SLOTS(EVENT_SLOTS),
      .DELAY_BITS (DELAY_BITS)
   ) checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_operation(req_operation),
      .req_event_id (req_event_id),
      .req_delay    (req_delay),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_kind     (rsp_kind),
      .rsp_fired_id (rsp_fired_id),
      .rsp_last     (rsp_last),
      .mismatches   (mismatches),
      .outstanding  (outstanding),
      .items_seen   (items_seen),
      .results_seen (results_seen),
      .fired_seen   (fired_seen),
      .errors_seen  (errors_seen)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog: cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", stall_cycles);
         $display("hashed_timing_wheel_tb failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Offer one item after a random gap and wait until it is taken
   task automatic offer_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                             input logic [DELAY_BITS-1:0] dly);
      int gap;
      gap = no_idle ? 0 : $urandom_range(5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_event_id  <= id;
      req_delay     <= dly;
      do @(posedge clock); while (!req_ready);
      if (op != OP_UNUSED)
         sent_items++;
   endtask

   // Delays cluster near zero and around the wheel size, with a few wide ones
   function automatic logic [DELAY_BITS-1:0] pick_delay();
      case ($urandom_range(9))
         0, 1, 2, 3, 4: pick_delay = DELAY_BITS'($urandom_range(6));
         5, 6:          pick_delay = DELAY_BITS'($urandom_range(100, 260));
         7:             pick_delay = DELAY_BITS'(WHEEL_SLOTS * $urandom_range(1, 3));
         8:             pick_delay = DELAY_BITS'($urandom);
         default:       pick_delay = $urandom_range(1) ? '1 : '0;
      endcase
   endfunction

   task automatic offer_random_item();
      int                roll;
      logic [OP_W-1:0]   op;
      logic [ID_W-1:0]   id;
      roll = $urandom_range(99);
      if (roll < 35)
         op = OP_TICK;
      else if (roll < 75)
         op = OP_SCHED;
      else if (roll < 95)
         op = OP_CANCEL;
      else
         op = OP_UNUSED;
      // a small id set makes busy and idle collisions frequent
      id = $urandom_range(1) ? ID_W'($urandom_range(7)) : ID_W'($urandom_range(63));
      offer_item(op, id, (op == OP_SCHED) ? pick_delay() : DELAY_BITS'($urandom));
   endtask

   task automatic run_mixed(input int upto);
      while (sent_items < upto) begin
         if ($urandom_range(15) == 0)
            no_idle = !no_idle;
         offer_random_item();
      end
   endtask

   // Stop offering until every owed result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   // Result side: random ready gaps, plus long hold-offs on request
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (hold_asked != hold_done) begin
            hold_done++;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = no_idle ? 0 : $urandom_range(5);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Item stimulus and verdict
   initial begin
      int burst_delay;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: delay floor, busy and idle errors, multi-fire tick,
      // empty tick, exact wheel multiple, turn decrement, wide delays
      offer_item(OP_SCHED, 6'd0, '0);
      offer_item(OP_SCHED, 6'd0, 24'd5);
      offer_item(OP_SCHED, 6'd63, '1);
      offer_item(OP_CANCEL, 6'd9, '0);
      offer_item(OP_SCHED, 6'd4, 24'd2);
      offer_item(OP_SCHED, 6'd5, 24'd2);
      offer_item(OP_SCHED, 6'd6, 24'd2);
      offer_item(OP_UNUSED, 6'd0, 24'd1);
      offer_item(OP_TICK, 6'd0, '0);
      offer_item(OP_TICK, 6'd63, '1);
      offer_item(OP_TICK, 6'd0, '0);
      offer_item(OP_CANCEL, 6'd63, '1);
      offer_item(OP_CANCEL, 6'd63, '0);
      offer_item(OP_SCHED, 6'd10, 24'd128);
      offer_item(OP_SCHED, 6'd11, 24'd129);
      offer_item(OP_SCHED, 6'd12, 24'd1);
      offer_item(OP_TICK, 6'd0, '0);
      offer_item(OP_SCHED, 6'd13, 24'd3);
      offer_item(OP_CANCEL, 6'd13, '0);
      offer_item(OP_SCHED, 6'd1, 24'h800000);
      offer_item(OP_SCHED, 6'd2, 24'h7FFFFF);

      run_mixed(110);
      drain_results();

      // Every slot armed on the same bucket: one tick fires all of them
      no_idle = 1'b1;
      for (int i = 0; i < EVENT_SLOTS; i++)
         offer_item(OP_CANCEL, ID_W'(i), DELAY_BITS'($urandom));
      burst_delay = $urandom_range(1, 3);
      for (int i = 0; i < EVENT_SLOTS; i++)
         offer_item(OP_SCHED, ID_W'(i), DELAY_BITS'(burst_delay));
      no_idle = 1'b0;
      repeat (3) offer_item(OP_TICK, ID_W'($urandom), DELAY_BITS'($urandom));

      // Result side stalls while items keep coming
      hold_asked++;
      run_mixed(290);

      // Full turn of the wheel around delays near its size
      for (int i = 0; i < 4; i++)
         offer_item(OP_CANCEL, ID_W'(i), '0);
      offer_item(OP_SCHED, 6'd0, DELAY_BITS'(WHEEL_SLOTS - 1));
      offer_item(OP_SCHED, 6'd1, DELAY_BITS'(WHEEL_SLOTS));
      offer_item(OP_SCHED, 6'd2, DELAY_BITS'(WHEEL_SLOTS + 1));
      offer_item(OP_SCHED, 6'd3, '0);
      for (int t = 0; t < WHEEL_SLOTS + 2; t++) begin
         if (t % 32 == 0)
            no_idle = ($urandom_range(3) == 0);
         offer_item(OP_TICK, ID_W'($urandom), DELAY_BITS'($urandom));
      end

      hold_asked++;
      run_mixed(460);

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d items and %0d results: %0d events fired, %0d busy/idle errors.",
               items_seen, results_seen, fired_seen, errors_seen);
      $display("Included a full-pool firing tick, a full wheel turn and two long stalls.");
      if (mismatches == 0 && outstanding == 0)
         $display("hashed_timing_wheel_tb passed");
      else
         $display("hashed_timing_wheel_tb failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/htw_pkg.sv
rtl/core/htw_div.sv
rtl/core/htw_dpath.sv
rtl/core/htw_ctrl.sv
rtl/core/hashed_timing_wheel.sv
rtl/core/htw_checker.sv
verif/htw_checker.sv
verif/hashed_timing_wheel_tb.sv
